[rtl/core/gwtc_pkg.sv]
// ----------------------------------------------------------------------------
// gwtc_pkg
// Field widths, calendar constants and reciprocal factors shared by the GPS
// week time to calendar converter and its channel interfaces.
// ----------------------------------------------------------------------------
package gwtc_pkg;

  // Channel field widths
  localparam int unsigned WEEK_W  = 13;
  localparam int unsigned SOW_W   = 20;
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // Internal widths
  localparam int unsigned DAYS_W  = 17;  // days since 1901-01-01, up to 86208
  localparam int unsigned SOD_W   = 17;  // second of day
  localparam int unsigned CYC_W   = 6;   // four-year cycles, up to 59
  localparam int unsigned LEFT_W  = 11;  // day within a four-year span, 0..1460
  localparam int unsigned REMH_W  = 12;  // second within the hour, 0..3599
  localparam int unsigned YDAY_W  = 9;   // day of year, 1..366

  // Pipeline depth
  localparam int unsigned NUM_STG = 8;

  // Calendar constants
  localparam int unsigned SEC_PER_DAY     = 86400;
  localparam int unsigned SEC_PER_HOUR    = 3600;
  localparam int unsigned SEC_PER_MIN     = 60;
  localparam int unsigned MAX_DAYS_IN_SOW = 12;     // whole days in a 20-bit second count
  localparam int unsigned GPS_EPOCH_DAYS  = 28859;  // MJD 44244 less MJD 15385 (1901-01-01)
  localparam int unsigned DAYS_PER_CYCLE  = 1461;
  localparam int unsigned DAYS_PER_YEAR   = 365;
  localparam int unsigned CYCLE_LAST_DAY  = 1460;
  localparam int unsigned BASE_YEAR       = 1901;
  localparam int unsigned DAYS_TO_2100    = 72684;

  // Reciprocals: floor(x / d) == (x * RECIP) >> SHIFT over each operand's range
  localparam int unsigned CYC_RECIP   = 91868;   // days / 1461, days <= 86208
  localparam int unsigned CYC_SHIFT   = 27;
  localparam int unsigned HOUR_RECIP  = 149131;  // sod / 3600, sod < 86400
  localparam int unsigned HOUR_SHIFT  = 29;
  localparam int unsigned MIN_RECIP   = 4370;    // remainder / 60, below 3600
  localparam int unsigned MIN_SHIFT   = 18;
  localparam int unsigned GUESS_RECIP = 2098;    // yday * 4 / 125, yday <= 366
  localparam int unsigned GUESS_SHIFT = 16;

  // Days before the start of month idx (0 is January); idx 12 and up give the
  // year length. Leap years add one from March on.
  function automatic logic [YDAY_W-1:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [YDAY_W-1:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + YDAY_W'(leap && (idx >= 4'd2));
  endfunction
endpackage

[rtl/core/gwtc_in_if.sv]
// ----------------------------------------------------------------------------
// gwtc_in_if
// Input channel: GPS week, whole second of the week and fraction of a second.
// ----------------------------------------------------------------------------
interface gwtc_in_if;
  import gwtc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WEEK_W-1:0] week_number;
  logic [SOW_W-1:0]  second_of_week;
  logic [FRAC_W-1:0] input_fraction;

  modport source (output valid, output week_number, output second_of_week,
                  output input_fraction, input ready);
  modport sink   (input valid, input week_number, input second_of_week,
                  input input_fraction, output ready);
endinterface

[rtl/core/gwtc_out_if.sv]
// ----------------------------------------------------------------------------
// gwtc_out_if
// Result channel: calendar date, time of day, fraction and range flag.
// ----------------------------------------------------------------------------
interface gwtc_out_if;
  import gwtc_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [MDAY_W-1:0]  day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   whole_second;
  logic [FRAC_W-1:0]  output_fraction;
  logic               out_of_range;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output whole_second,
                  output output_fraction, output out_of_range, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input whole_second,
                  input output_fraction, input out_of_range, output ready);
endinterface

[rtl/core/gps_week_time_to_calendar.sv]
// Throughput: one transfer per cycle unless the output stalls; the eight
// stage registers each advance on their own enable, so a stalled output
// holds only the stages behind it.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers
// are not reset and are qualified by their valid bit.
// ----------------------------------------------------------------------------
// gps_week_time_to_calendar
// Converts a GPS week time to calendar year, month, day and time of day.
// Divisions by constants are reciprocal multiplies, each followed by a
// stage register before the remainder is formed.
// ----------------------------------------------------------------------------
module gps_week_time_to_calendar (
  input  logic         clk,
  input  logic         rst_n,
  gwtc_in_if.sink      in_ch,
  gwtc_out_if.source   out_ch
);
  import gwtc_pkg::*;

  // Stage enables and valid bits, index 0 is the first stage
  logic [NUM_STG-1:0] stg_en;
  logic [NUM_STG-1:0] vld_r;

  // Stage 1: whole days in the week, week scaled to days
  logic [3:0]         dcnt_nxt;
  logic [3:0]         s1_dcnt_r;
  logic [15:0]        s1_week7_r;
  logic [SOW_W-1:0]   s1_sow_r;

  // Stage 2: day count since 1901-01-01, second of day
  logic [DAYS_W-1:0]  s2_days_r;
  logic [SOD_W-1:0]   s2_sod_r;

  // Stage 3: four-year cycle count and hour by reciprocal
  logic [33:0]        cyc_prod;
  logic [33:0]        hr_prod;
  logic [DAYS_W-1:0]  s3_days_r;
  logic [SOD_W-1:0]   s3_sod_r;
  logic [CYC_W-1:0]   s3_cyc_r;
  logic [HOUR_W-1:0]  s3_hr_r;
  logic               s3_oor_r;

  // Stage 4: day within the cycle, second within the hour
  logic [LEFT_W-1:0]  s4_left_r;
  logic [REMH_W-1:0]  s4_remh_r;
  logic [CYC_W-1:0]   s4_cyc_r;
  logic [HOUR_W-1:0]  s4_hr_r;
  logic               s4_oor_r;

  // Stage 5: whole years into the cycle, minute by reciprocal
  logic [2:0]         q365;
  logic [1:0]         dyrs_nxt;
  logic [23:0]        mn_prod;
  logic [1:0]         s5_dyrs_r;
  logic [MIN_W-1:0]   s5_mn_r;
  logic [LEFT_W-1:0]  s5_left_r;
  logic [REMH_W-1:0]  s5_remh_r;
  logic [CYC_W-1:0]   s5_cyc_r;
  logic [HOUR_W-1:0]  s5_hr_r;
  logic               s5_oor_r;

  // Stage 6: year, day of year, whole second
  logic [LEFT_W-1:0]  yday_full;
  logic [REMH_W-1:0]  sec_full;
  logic [YEAR_W-1:0]  s6_year_r;
  logic [YDAY_W-1:0]  s6_yday_r;
  logic [SEC_W-1:0]   s6_sec_r;
  logic [MIN_W-1:0]   s6_mn_r;
  logic [HOUR_W-1:0]  s6_hr_r;
  logic               s6_oor_r;

  // Stage 7: month estimate
  logic [20:0]        guess_prod;
  logic [3:0]         s7_guess_r;
  logic               s7_leap_r;
  logic [YEAR_W-1:0]  s7_year_r;
  logic [YDAY_W-1:0]  s7_yday_r;
  logic [SEC_W-1:0]   s7_sec_r;
  logic [MIN_W-1:0]   s7_mn_r;
  logic [HOUR_W-1:0]  s7_hr_r;
  logic               s7_oor_r;

  // Stage 8: output register
  logic               more;
  logic [3:0]         mon_idx;
  logic [YDAY_W-1:0]  mday_full;
  logic [YEAR_W-1:0]  s8_year_r;
  logic [MONTH_W-1:0] s8_month_r;
  logic [MDAY_W-1:0]  s8_mday_r;
  logic [HOUR_W-1:0]  s8_hr_r;
  logic [MIN_W-1:0]   s8_mn_r;
  logic [SEC_W-1:0]   s8_sec_r;
  logic               s8_oor_r;

  // Fraction rides alongside every stage untouched
  logic [FRAC_W-1:0]  frac_r [NUM_STG];

  // --------------------------------------------------------------------------
  // Flow control: a stage may load when it is empty or when the stage after
  // it loads in the same cycle. Bubbles collapse, so while a finished result
  // waits in the output register, new transfers enter until all stages fill.
  // --------------------------------------------------------------------------
  always_comb begin
    stg_en[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ch.ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      stg_en[i] = !vld_r[i] || stg_en[i+1];
    end
  end

  assign in_ch.ready = stg_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (stg_en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      frac_r[0] <= in_ch.input_fraction;
    end
    for (int i = 1; i < NUM_STG; i++) begin
      if (stg_en[i]) begin
        frac_r[i] <= frac_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: count whole days in the second of week with twelve parallel
  // threshold compares; the field can reach beyond one week, hence twelve.
  // --------------------------------------------------------------------------
  always_comb begin
    dcnt_nxt = '0;
    for (int k = 1; k <= MAX_DAYS_IN_SOW; k++) begin
      dcnt_nxt = dcnt_nxt + 4'(in_ch.second_of_week >= SOW_W'(k * SEC_PER_DAY));
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      s1_dcnt_r  <= dcnt_nxt;
      s1_week7_r <= 16'(16'(in_ch.week_number) * 16'd7);
      s1_sow_r   <= in_ch.second_of_week;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: days since 1901-01-01 (MJD minus 15385) and the second of day.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s2_days_r <= DAYS_W'(s1_week7_r) + DAYS_W'(s1_dcnt_r) + DAYS_W'(GPS_EPOCH_DAYS);
      s2_sod_r  <= SOD_W'(s1_sow_r - SOW_W'(21'(s1_dcnt_r) * 21'(SEC_PER_DAY)));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: cycles = days / 1461 and hour = sod / 3600 by reciprocal
  // multiply; both are exact over the reachable ranges. Flag dates from
  // 2100-01-01 on here, while the full day count is at hand.
  // --------------------------------------------------------------------------
  assign cyc_prod = 34'(s2_days_r) * 34'(CYC_RECIP);
  assign hr_prod  = 34'(s2_sod_r) * 34'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      s3_days_r <= s2_days_r;
      s3_sod_r  <= s2_sod_r;
      s3_cyc_r  <= cyc_prod[CYC_SHIFT +: CYC_W];
      s3_hr_r   <= hr_prod[HOUR_SHIFT +: HOUR_W];
      s3_oor_r  <= s2_days_r >= DAYS_W'(DAYS_TO_2100);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: remainders of both divisions.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      s4_left_r <= LEFT_W'(s3_days_r - DAYS_W'(DAYS_W'(s3_cyc_r) * DAYS_W'(DAYS_PER_CYCLE)));
      s4_remh_r <= REMH_W'(s3_sod_r - SOD_W'(SOD_W'(s3_hr_r) * SOD_W'(SEC_PER_HOUR)));
      s4_cyc_r  <= s3_cyc_r;
      s4_hr_r   <= s3_hr_r;
      s4_oor_r  <= s3_oor_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: years into the cycle. The last day of a cycle would count as a
  // fifth year; pull it back into the fourth, leap, year.
  // --------------------------------------------------------------------------
  always_comb begin
    q365 = 3'(s4_left_r >= LEFT_W'(DAYS_PER_YEAR))
         + 3'(s4_left_r >= LEFT_W'(2 * DAYS_PER_YEAR))
         + 3'(s4_left_r >= LEFT_W'(3 * DAYS_PER_YEAR))
         + 3'(s4_left_r >= LEFT_W'(4 * DAYS_PER_YEAR));
    dyrs_nxt = 2'(q365 - 3'(s4_left_r == LEFT_W'(CYCLE_LAST_DAY)));
  end

  assign mn_prod = 24'(s4_remh_r) * 24'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      s5_dyrs_r <= dyrs_nxt;
      s5_mn_r   <= mn_prod[MIN_SHIFT +: MIN_W];
      s5_left_r <= s4_left_r;
      s5_remh_r <= s4_remh_r;
      s5_cyc_r  <= s4_cyc_r;
      s5_hr_r   <= s4_hr_r;
      s5_oor_r  <= s4_oor_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: year, day of year (from 1) and whole second of the minute.
  // --------------------------------------------------------------------------
  assign yday_full = s5_left_r - LEFT_W'(LEFT_W'(s5_dyrs_r) * LEFT_W'(DAYS_PER_YEAR))
                   + LEFT_W'(1);
  assign sec_full  = s5_remh_r - REMH_W'(REMH_W'(s5_mn_r) * REMH_W'(SEC_PER_MIN));

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      s6_year_r <= YEAR_W'(BASE_YEAR) + {YEAR_W'(s5_cyc_r) << 2} + YEAR_W'(s5_dyrs_r);
      s6_yday_r <= YDAY_W'(yday_full);
      s6_sec_r  <= SEC_W'(sec_full);
      s6_mn_r   <= s5_mn_r;
      s6_hr_r   <= s5_hr_r;
      s6_oor_r  <= s5_oor_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: month estimate floor(yday * 4 / 125), folded into one multiply.
  // Every fourth year is leap, no century rule.
  // --------------------------------------------------------------------------
  assign guess_prod = 21'(s6_yday_r) * 21'(GUESS_RECIP);

  always_ff @(posedge clk) begin
    if (stg_en[6]) begin
      s7_guess_r <= guess_prod[GUESS_SHIFT +: 4];
      s7_leap_r  <= s6_year_r[1:0] == 2'b00;
      s7_year_r  <= s6_year_r;
      s7_yday_r  <= s6_yday_r;
      s7_sec_r   <= s6_sec_r;
      s7_mn_r    <= s6_mn_r;
      s7_hr_r    <= s6_hr_r;
      s7_oor_r   <= s6_oor_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: step the estimate forward by one month where the day lies past
  // the next month's start, then take the day of month.
  // --------------------------------------------------------------------------
  always_comb begin
    more      = s7_yday_r > cum_days(s7_leap_r, s7_guess_r + 4'd1);
    mon_idx   = s7_guess_r + 4'(more);
    mday_full = s7_yday_r - cum_days(s7_leap_r, mon_idx);
  end

  always_ff @(posedge clk) begin
    if (stg_en[7]) begin
      s8_year_r  <= s7_year_r;
      s8_month_r <= MONTH_W'(mon_idx + 4'd1);
      s8_mday_r  <= MDAY_W'(mday_full);
      s8_hr_r    <= s7_hr_r;
      s8_mn_r    <= s7_mn_r;
      s8_sec_r   <= s7_sec_r;
      s8_oor_r   <= s7_oor_r;
    end
  end

  assign out_ch.valid           = vld_r[NUM_STG-1];
  assign out_ch.year            = s8_year_r;
  assign out_ch.month           = s8_month_r;
  assign out_ch.day_of_month    = s8_mday_r;
  assign out_ch.hour            = s8_hr_r;
  assign out_ch.minute          = s8_mn_r;
  assign out_ch.whole_second    = s8_sec_r;
  assign out_ch.output_fraction = frac_r[NUM_STG-1];
  assign out_ch.out_of_range    = s8_oor_r;

`ifndef SYNTH
  // Day within a four-year span and second within an hour must stay below their divisors
  a_rem_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (s4_left_r <= LEFT_W'(CYCLE_LAST_DAY)) &&
                 (s4_remh_r < REMH_W'(SEC_PER_HOUR)))
    else $error("cycle or hour remainder out of bounds");

  a_date_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.month >= MONTH_W'(1)) && (out_ch.month <= MONTH_W'(12)) &&
                     (out_ch.day_of_month >= MDAY_W'(1)))
    else $error("month or day of month out of bounds");

  a_time_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hour < HOUR_W'(24)) && (out_ch.minute < MIN_W'(60)) &&
                     (out_ch.whole_second < SEC_W'(60)))
    else $error("time of day out of bounds");

  a_input_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("input transfer not captured in first stage");
`endif

endmodule

[sim/gps_week_time_to_calendar_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gps_week_time_to_calendar_tb
// Drives GPS week times into the converter, predicts the calendar date and
// time of day for each transfer, and checks every result in order.
// ----------------------------------------------------------------------------
module gps_week_time_to_calendar_tb;
  import gwtc_pkg::*;

  localparam int unsigned CLOCK_HALF    = 4;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned DRAIN_CYCLES  = 20;      // pipeline is eight deep
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned ITEMS_PER_RUN = 511;     // per idling phase
  localparam int unsigned REPORT_MAX    = 10;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned MJD_AT_EPOCH  = 44244;   // 1980-01-06
  localparam int unsigned MJD_AT_1901   = 15385;
  localparam int unsigned CYCLE_DAYS    = 1461;
  localparam int unsigned YEAR_DAYS     = 365;
  localparam int unsigned LAST_CYC_DAY  = 1460;
  localparam int unsigned FIRST_YEAR    = 1901;
  localparam int unsigned DAYS_TO_2100  = 72684;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   whole_second;
    logic [FRAC_W-1:0]  output_fraction;
    logic               out_of_range;
  } calendar_t;

  // --------------------------------------------------------------------------
  // Calendar predictor and in-order store of the dates still to come out
  // --------------------------------------------------------------------------
  class calendar_checker;
    calendar_t   pending_dates[$];
    int unsigned mismatches;
    int unsigned month_start[2][13] = '{
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
      '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
    };

    function automatic calendar_t gps_to_calendar(logic [WEEK_W-1:0] week,
                                                  logic [SOW_W-1:0]  sow,
                                                  logic [FRAC_W-1:0] frac);
      calendar_t   date;
      int unsigned days, cycles, left, dyrs, yr, yday, sod, leap, guess, more;
      int unsigned next_idx, this_idx;
      days   = int'(week) * 7 + int'(sow) / SECS_PER_DAY + MJD_AT_EPOCH - MJD_AT_1901;
      cycles = days / CYCLE_DAYS;
      left   = days - CYCLE_DAYS * cycles;
      // the last day of a cycle belongs to the leap year, not a fifth year
      dyrs   = left / YEAR_DAYS - left / LAST_CYC_DAY;
      yr     = FIRST_YEAR + 4 * cycles + dyrs;
      yday   = left - YEAR_DAYS * dyrs + 1;
      leap   = (yr % 4 == 0) ? 1 : 0;
      // month guess may be one short; correct it from the month table
      guess    = (yday * 4) / 125;
      next_idx = (guess + 1 > 12) ? 12 : guess + 1;
      more     = (yday > month_start[leap][next_idx]) ? 1 : 0;
      this_idx = (guess + more > 12) ? 12 : guess + more;
      sod      = int'(sow) % SECS_PER_DAY;
      date.year            = yr[YEAR_W-1:0];
      date.month           = MONTH_W'(guess + more + 1);
      date.day_of_month    = MDAY_W'(yday - month_start[leap][this_idx]);
      date.hour            = HOUR_W'(sod / 3600);
      date.minute          = MIN_W'((sod % 3600) / 60);
      date.whole_second    = SEC_W'(sod % 60);
      date.output_fraction = frac;
      date.out_of_range    = (days >= DAYS_TO_2100);
      return date;
    endfunction

    function automatic string show(calendar_t d);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d frac=%h oor=%b", d.year, d.month,
                       d.day_of_month, d.hour, d.minute, d.whole_second,
                       d.output_fraction, d.out_of_range);
    endfunction

    function automatic void note_timestamp(logic [WEEK_W-1:0] week,
                                           logic [SOW_W-1:0]  sow,
                                           logic [FRAC_W-1:0] frac);
      pending_dates.push_back(gps_to_calendar(week, sow, frac));
    endfunction

    function automatic void check_date(calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected result %s", show(got));
        return;
      end
      want = pending_dates.pop_front();
      if (got.year !== want.year || got.month !== want.month ||
          got.day_of_month !== want.day_of_month || got.hour !== want.hour ||
          got.minute !== want.minute || got.whole_second !== want.whole_second ||
          got.output_fraction !== want.output_fraction ||
          got.out_of_range !== want.out_of_range) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #CLOCK_HALF clk = 1'b1;
    #CLOCK_HALF clk = 1'b0;
  end

  gwtc_in_if  in_ch ();
  gwtc_out_if out_ch ();

  gps_week_time_to_calendar DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  calendar_checker dates = new();
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     cycle_count;

  // --------------------------------------------------------------------------
  // Watch both channels. Values read here are the ones from just before the
  // edge, since every driver uses nonblocking assignments.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    calendar_t got;
    if (rst_n && in_ch.valid && in_ch.ready)
      dates.note_timestamp(in_ch.week_number, in_ch.second_of_week, in_ch.input_fraction);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{year: out_ch.year, month: out_ch.month,
              day_of_month: out_ch.day_of_month, hour: out_ch.hour,
              minute: out_ch.minute, whole_second: out_ch.whole_second,
              output_fraction: out_ch.output_fraction,
              out_of_range: out_ch.out_of_range};
      dates.check_date(got);
    end
    // stall the result channel at random
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Offer one timestamp and hold it until the block takes the transfer
  // --------------------------------------------------------------------------
  task automatic send_timestamp(input logic [WEEK_W-1:0] week,
                                input logic [SOW_W-1:0]  sow,
                                input logic [FRAC_W-1:0] frac);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.week_number    <= week;
    in_ch.second_of_week <= sow;
    in_ch.input_fraction <= frac;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Mostly dates up to 2099, with a share past 2100, past the week end,
  // fully random bit patterns and the first and last second of a day.
  task automatic send_random_timestamps(input int unsigned count);
    int unsigned       kind;
    logic [WEEK_W-1:0] week;
    logic [SOW_W-1:0]  sow;
    logic [FRAC_W-1:0] frac;
    for (int unsigned n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      frac = $urandom();
      if (kind < 60) begin
        week = WEEK_W'($urandom_range(6260));
        sow  = SOW_W'($urandom_range(604799));
      end else if (kind < 75) begin
        week = WEEK_W'($urandom_range(8191, 6250));
        sow  = SOW_W'($urandom_range(604799));
      end else if (kind < 85) begin
        week = WEEK_W'($urandom_range(8191));
        sow  = SOW_W'($urandom_range(1048575, 604800));
      end else if (kind < 95) begin
        week = WEEK_W'($urandom());
        sow  = SOW_W'($urandom());
      end else begin
        week = WEEK_W'($urandom_range(8191));
        sow  = SOW_W'(SECS_PER_DAY * $urandom_range(11) + ($urandom_range(1) ? 86399 : 0));
      end
      send_timestamp(week, sow, frac);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.week_number    <= '0;
    in_ch.second_of_week <= '0;
    in_ch.input_fraction <= '0;
    send_idle_pct = 30;
    recv_idle_pct = 59;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, leap handling and the 2100 boundary
    send_timestamp(13'd0, 20'd0, 32'h0000_0000);             // GPS epoch
    send_timestamp(13'd0, 20'd604799, 32'hFFFF_FFFF);        // last second of week zero
    send_timestamp(13'd1, 20'd49662, 32'h0000_0001);         // 13:47:42
    send_timestamp(13'd51, 20'd259200, 32'h8000_0000);       // 1980-12-31, last day of a cycle
    send_timestamp(13'd59, 20'd518400, 32'h1234_5678);       // 1981-02-28
    send_timestamp(13'd60, 20'd0, 32'h8765_4321);            // 1981-03-01
    send_timestamp(13'd1051, 20'd172800, 32'h0F0F_0F0F);     // 2000-02-29
    send_timestamp(13'd1051, 20'd259199, 32'hF0F0_F0F0);     // end of the leap day
    send_timestamp(13'd6260, 20'd431999, 32'hFFFF_FFFE);     // 2099-12-31 23:59:59
    send_timestamp(13'd6260, 20'd432000, 32'h0000_0002);     // 2100-01-01, flagged
    send_timestamp(13'd6269, 20'd86400, 32'hDEAD_BEEF);      // real 2100-03-01; read as 2100-02-29 with no century rule
    send_timestamp(13'd0, 20'd604800, 32'h7FFF_FFFF);        // seconds past the week end
    send_timestamp(13'd0, 20'd1048575, 32'h0000_FFFF);
    send_timestamp(13'd8191, 20'd0, 32'h0000_0000);
    send_timestamp(13'd8191, 20'd1048575, 32'hFFFF_FFFF);    // every field at its top
    send_timestamp(13'h1555, 20'hAAAAA, 32'h5555_5555);
    send_timestamp(13'h0AAA, 20'h55555, 32'hAAAA_AAAA);

    send_random_timestamps(ITEMS_PER_RUN);

    // swap the idling between the two sides
    send_idle_pct = 59;
    recv_idle_pct = 30;
    send_random_timestamps(ITEMS_PER_RUN);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_timestamps(ITEMS_PER_RUN);
    in_ch.valid <= 1'b0;

    // drain, then give any stray result a chance to show up
    while (dates.pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (dates.mismatches == 0 && dates.pending_dates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
